>>> design/dntp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal number token parser package
// Character codes, parser phases and fixed-point constants for the parser.
// ----------------------------------------------------------------------------
package dntp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_INT,
        PH_FRAC
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 5;
    localparam int POS_BITS    = 16;
    localparam int INT_BITS    = 32;
    localparam int FRAC_W      = 17;
    localparam int FDIG_W      = 3;
    localparam int VAL_BITS    = 48;

    localparam logic [INT_BITS-1:0] INT_MAX_MAG = 32'h7FFF_FFFF;
    localparam logic [POS_BITS-1:0] POS_LIM     = 16'hFFFF;
    localparam logic [VAL_BITS-1:0] MAG_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [FDIG_W-1:0]   FDIG_MAX    = FDIG_W'(FRAC_DIGITS);

    // The fraction is kept as five decimal digits F, and the binary fraction is
    // floor((F * 2048 + 1562) / 3125), taken by a reciprocal multiply.
    localparam int             QUOT_NUM_W  = 28;
    localparam int             RECIP_W     = 29;
    localparam int             PROD_W      = QUOT_NUM_W + RECIP_W;
    localparam int             RECIP_SHIFT = 40;
    localparam logic [10:0]    FRAC_HALF   = 11'd1562;
    localparam logic [RECIP_W-1:0] RECIP_3125 = 29'd351843721;

    function automatic logic [FRAC_W-1:0] frac_weight(input logic [FDIG_W-1:0] k);
        logic [FRAC_W-1:0] w;
        begin
            unique case (k)
                3'd0:    w = 17'd10000;
                3'd1:    w = 17'd1000;
                3'd2:    w = 17'd100;
                3'd3:    w = 17'd10;
                3'd4:    w = 17'd1;
                default: w = 17'd0;
            endcase
            return w;
        end
    endfunction

endpackage

>>> design/decimal_number_token_parser_top.sv
// ----------------------------------------------------------------------------
// Decimal number token parser
// Parses a stream of ASCII characters into unsigned 32-bit integers or signed Q31.16 values.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result side does not stall.
// Pipeline: the token ended by an accepted character passes the snapshot,
// reciprocal multiply and output registers in turn; each holds while the
// stage after it is stalled.
// Reset: aresetn is synchronous and active low; it clears the mode register,
// returns the parser to idle and empties the result pipeline.
module decimal_number_token_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ch [7:0], offset [23:8]
    input  logic [0:0]  s_tuser,   // start_req [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value [47:0], position [63:48]
    output logic [0:0]  m_tuser    // ok [0]
);

    logic [7:0]                          ch;
    logic                                start_req;
    logic [dntp_pkg::POS_BITS-1:0]       offset;
    logic                                accept;
    logic                                is_ws;
    logic                                is_dig;
    logic                                is_term;
    logic [3:0]                          digit;

    logic                                mode_reg;
    dntp_pkg::phase_t                    phase_reg, phase_next;
    logic                                tok_mode_reg, tok_mode_next;
    logic [dntp_pkg::INT_BITS-1:0]       int_reg, int_next;
    logic [dntp_pkg::FRAC_W-1:0]         frac_reg, frac_next;
    logic [dntp_pkg::FDIG_W-1:0]         fdig_reg, fdig_next;
    logic                                neg_reg, neg_next;
    logic                                seen_reg, seen_next;
    logic [dntp_pkg::POS_BITS-1:0]       count_reg, count_next;
    logic [dntp_pkg::POS_BITS-1:0]       base_reg, base_next;
    logic                                finish;

    logic [dntp_pkg::INT_BITS-1:0]       s1_int_next;
    logic [dntp_pkg::FRAC_W-1:0]         s1_frac_next;
    logic                                s1_neg_next;
    logic                                s1_mode_next;
    logic                                s1_ok_next;
    logic [dntp_pkg::POS_BITS-1:0]       s1_base_next;
    logic [dntp_pkg::POS_BITS-1:0]       s1_count_next;

    logic                                e1, e2, e3;
    logic                                s1_valid_reg;
    logic [dntp_pkg::INT_BITS-1:0]       s1_int_reg;
    logic [dntp_pkg::FRAC_W-1:0]         s1_frac_reg;
    logic                                s1_neg_reg;
    logic                                s1_mode_reg;
    logic                                s1_ok_reg;
    logic [dntp_pkg::POS_BITS-1:0]       s1_base_reg;
    logic [dntp_pkg::POS_BITS-1:0]       s1_count_reg;

    logic [dntp_pkg::POS_BITS:0]         pos_sum;
    logic [dntp_pkg::POS_BITS-1:0]       pos_sat;
    logic [dntp_pkg::QUOT_NUM_W-1:0]     quot_num;
    logic [dntp_pkg::PROD_W-1:0]         prod;

    logic                                s2_valid_reg;
    logic [dntp_pkg::INT_BITS-1:0]       s2_int_reg;
    logic [dntp_pkg::FRAC_W-1:0]         s2_fr_reg;
    logic                                s2_neg_reg;
    logic                                s2_mode_reg;
    logic                                s2_ok_reg;
    logic [dntp_pkg::POS_BITS-1:0]       s2_pos_reg;

    logic [dntp_pkg::VAL_BITS:0]         mag_sum;
    logic [dntp_pkg::VAL_BITS-1:0]       mag;
    logic [dntp_pkg::VAL_BITS-1:0]       value_calc;

    logic                                m_valid_reg;
    logic [dntp_pkg::VAL_BITS-1:0]       m_value_reg;
    logic                                m_ok_reg;
    logic [dntp_pkg::POS_BITS-1:0]       m_pos_reg;

    assign ch        = s_tdata[7:0];
    assign offset    = s_tdata[23:8];
    assign start_req = s_tuser[0];

    assign e3       = !m_valid_reg || m_tready;
    assign e2       = !s2_valid_reg || e3;
    assign e1       = !s1_valid_reg || e2;
    assign s_tready = e1;
    assign accept   = s_tvalid && s_tready;

    assign is_ws   = ((ch >= dntp_pkg::CH_TAB) && (ch <= dntp_pkg::CH_CR))
                     || (ch == dntp_pkg::CH_SPACE);
    assign is_dig  = (ch >= dntp_pkg::CH_ZERO) && (ch <= dntp_pkg::CH_NINE);
    assign is_term = is_ws || (ch == dntp_pkg::CH_NUL) || (ch == dntp_pkg::CH_COMMA);
    assign digit   = 4'(ch - dntp_pkg::CH_ZERO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata[0];
        end
    end

    always_comb begin
        logic [dntp_pkg::POS_BITS-1:0] count_inc;
        logic [35:0]                   int_mul;
        logic                          done;
        dntp_pkg::phase_t              work_phase;

        phase_next    = phase_reg;
        tok_mode_next = tok_mode_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        fdig_next     = fdig_reg;
        neg_next      = neg_reg;
        seen_next     = seen_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        if (start_req) begin
            phase_next    = dntp_pkg::PH_LEAD;
            tok_mode_next = mode_reg;
            int_next      = '0;
            frac_next     = '0;
            fdig_next     = '0;
            neg_next      = 1'b0;
            seen_next     = 1'b0;
            count_next    = '0;
            base_next     = offset;
        end

        count_inc  = (count_next < dntp_pkg::POS_LIM) ? count_next + 1'b1 : count_next;
        int_mul    = {int_next, 3'b000} + {3'b000, int_next, 1'b0} + 36'(digit);
        finish     = 1'b0;
        done       = 1'b0;
        work_phase = phase_next;

        // Snapshot of the token as it stands before this character.
        s1_int_next   = int_next;
        s1_frac_next  = frac_next;
        s1_neg_next   = neg_next;
        s1_mode_next  = tok_mode_next;
        s1_ok_next    = seen_next && is_term;
        s1_base_next  = base_next;
        s1_count_next = count_next;

        if (work_phase == dntp_pkg::PH_LEAD) begin
            if (is_ws) begin
                count_next = count_inc;
                done       = 1'b1;
            end else begin
                work_phase = dntp_pkg::PH_INT;
                phase_next = dntp_pkg::PH_INT;
                if (tok_mode_next && (ch == dntp_pkg::CH_MINUS)) begin
                    neg_next   = 1'b1;
                    count_next = count_inc;
                    done       = 1'b1;
                end
            end
        end

        if (!done) begin
            unique case (work_phase)
                dntp_pkg::PH_INT: begin
                    if (is_dig) begin
                        if (!tok_mode_next) begin
                            int_next = int_mul[dntp_pkg::INT_BITS-1:0];
                        end else if (int_mul > 36'(dntp_pkg::INT_MAX_MAG)) begin
                            int_next = dntp_pkg::INT_MAX_MAG;
                        end else begin
                            int_next = int_mul[dntp_pkg::INT_BITS-1:0];
                        end
                        seen_next  = 1'b1;
                        count_next = count_inc;
                    end else if (tok_mode_next && (ch == dntp_pkg::CH_POINT)) begin
                        phase_next = dntp_pkg::PH_FRAC;
                        count_next = count_inc;
                    end else begin
                        finish     = 1'b1;
                        phase_next = dntp_pkg::PH_IDLE;
                    end
                end
                dntp_pkg::PH_FRAC: begin
                    if (is_dig) begin
                        seen_next = 1'b1;
                        if (fdig_next < dntp_pkg::FDIG_MAX) begin
                            frac_next = frac_next + dntp_pkg::FRAC_W'(
                                        dntp_pkg::frac_weight(fdig_next) * 17'(digit));
                            fdig_next = fdig_next + 1'b1;
                        end
                        count_next = count_inc;
                    end else begin
                        finish     = 1'b1;
                        phase_next = dntp_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dntp_pkg::PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tok_mode_reg <= tok_mode_next;
            int_reg      <= int_next;
            frac_reg     <= frac_next;
            fdig_reg     <= fdig_next;
            neg_reg      <= neg_next;
            seen_reg     <= seen_next;
            count_reg    <= count_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (e1) begin
            s1_valid_reg <= accept && finish;
        end
    end

    always_ff @(posedge aclk) begin
        if (e1) begin
            s1_int_reg   <= s1_int_next;
            s1_frac_reg  <= s1_frac_next;
            s1_neg_reg   <= s1_neg_next;
            s1_mode_reg  <= s1_mode_next;
            s1_ok_reg    <= s1_ok_next;
            s1_base_reg  <= s1_base_next;
            s1_count_reg <= s1_count_next;
        end
    end

    assign pos_sum  = {1'b0, s1_base_reg} + {1'b0, s1_count_reg};
    assign pos_sat  = pos_sum[dntp_pkg::POS_BITS] ? dntp_pkg::POS_LIM
                                                  : pos_sum[dntp_pkg::POS_BITS-1:0];
    assign quot_num = {s1_frac_reg, dntp_pkg::FRAC_HALF};
    assign prod     = dntp_pkg::PROD_W'(quot_num) * dntp_pkg::PROD_W'(dntp_pkg::RECIP_3125);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (e2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e2) begin
            s2_int_reg  <= s1_int_reg;
            s2_fr_reg   <= prod[dntp_pkg::RECIP_SHIFT +: dntp_pkg::FRAC_W];
            s2_neg_reg  <= s1_neg_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_pos_reg  <= s1_ok_reg ? pos_sat : '0;
        end
    end

    always_comb begin
        logic [dntp_pkg::INT_BITS-1:0] im;

        im = (s2_int_reg > dntp_pkg::INT_MAX_MAG) ? dntp_pkg::INT_MAX_MAG : s2_int_reg;
        mag_sum = {1'b0, im, {dntp_pkg::FRAC_BITS{1'b0}}} + (dntp_pkg::VAL_BITS + 1)'(s2_fr_reg);
        mag = (mag_sum > (dntp_pkg::VAL_BITS + 1)'(dntp_pkg::MAG_MAX))
              ? dntp_pkg::MAG_MAX : mag_sum[dntp_pkg::VAL_BITS-1:0];
        if (!s2_mode_reg) begin
            value_calc = dntp_pkg::VAL_BITS'(s2_int_reg);
        end else if (s2_neg_reg) begin
            value_calc = '0 - mag;
        end else begin
            value_calc = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (e3) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e3) begin
            m_value_reg <= value_calc;
            m_ok_reg    <= s2_ok_reg;
            m_pos_reg   <= s2_pos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pos_reg, m_value_reg};
    assign m_tuser  = m_ok_reg;

endmodule

>>> tb/sv/dntp_token_checker.sv
// ----------------------------------------------------------------------------
// Decimal token parser result checker
// Watches the character and result channels and the mode register writes,
// predicts each token value, ok flag and end position, and compares every
// result word with the oldest prediction.
// ----------------------------------------------------------------------------
module dntp_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // ch [7:0], offset [23:8]
    input  logic [0:0]  s_tuser,   // start_req [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // value [47:0], position [63:48]
    input  logic [0:0]  m_tuser,   // ok [0]
    output int          err_count,
    output int          pending_count,
    output int          result_count,
    output int          ok_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [47:0] value;
        logic        ok;
        logic [15:0] position;
    } token_t;

    token_t      token_q[$];

    logic              cfg_mode;
    logic              tok_mode;
    dntp_pkg::phase_t  tok_phase;
    logic [32:0]       int_acc;
    logic [16:0]       frac_acc;
    logic [2:0]        frac_cnt;
    logic              neg;
    logic              got_digit;
    logic [15:0]       used_cnt;
    logic [15:0]       base_pos;
    int                n_err = 0;
    int                n_res = 0;
    int                n_ok  = 0;

    function automatic bit is_space(input logic [7:0] c);
        return (c >= dntp_pkg::CH_TAB && c <= dntp_pkg::CH_CR) || c == dntp_pkg::CH_SPACE;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dntp_pkg::CH_ZERO && c <= dntp_pkg::CH_NINE;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_err++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h",
                 $realtime, what, got, want);
    endtask

    task automatic clear_token();
        int_acc   = '0;
        frac_acc  = '0;
        frac_cnt  = '0;
        neg       = 1'b0;
        got_digit = 1'b0;
        used_cnt  = '0;
    endtask

    task automatic count_char();
        if (used_cnt < dntp_pkg::POS_LIM)
            used_cnt = used_cnt + 16'd1;
    endtask

    task automatic close_token(input logic [7:0] c, output token_t res);
        logic [63:0] p;
        logic [63:0] fr;
        logic [63:0] im;
        logic [63:0] mag;
        logic [63:0] sv;
        logic [63:0] pos;
        if (!tok_mode) begin
            res.value = {16'd0, int_acc[31:0]};
        end else begin
            p = 64'd1;
            for (int i = 0; i < frac_cnt; i++)
                p = p * 64'd10;
            fr  = ((64'(frac_acc) << dntp_pkg::FRAC_BITS) + p / 64'd2) / p;
            im  = (64'(int_acc) > 64'(dntp_pkg::INT_MAX_MAG)) ? 64'(dntp_pkg::INT_MAX_MAG)
                                                              : 64'(int_acc);
            mag = (im << dntp_pkg::FRAC_BITS) + fr;
            if (mag > 64'(dntp_pkg::MAG_MAX))
                mag = 64'(dntp_pkg::MAG_MAX);
            sv = neg ? (64'd0 - mag) : mag;
            res.value = sv[47:0];
        end
        res.ok = got_digit && (is_space(c) || c == dntp_pkg::CH_NUL
                               || c == dntp_pkg::CH_COMMA);
        pos = 64'(base_pos) + 64'(used_cnt);
        if (pos > 64'(dntp_pkg::POS_LIM))
            pos = 64'(dntp_pkg::POS_LIM);
        res.position = res.ok ? pos[15:0] : 16'd0;
        tok_phase = dntp_pkg::PH_IDLE;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic start,
                              input logic [15:0] off, output bit done,
                              output token_t res);
        logic [63:0] n;
        done = 1'b0;
        res  = '0;
        if (start) begin
            clear_token();
            base_pos  = (off > dntp_pkg::POS_LIM) ? dntp_pkg::POS_LIM : off;
            tok_mode  = cfg_mode;
            tok_phase = dntp_pkg::PH_LEAD;
        end
        if (tok_phase == dntp_pkg::PH_IDLE)
            return;
        if (tok_phase == dntp_pkg::PH_LEAD) begin
            if (is_space(c)) begin
                count_char();
                return;
            end
            tok_phase = dntp_pkg::PH_INT;
            if (tok_mode && c == dntp_pkg::CH_MINUS) begin
                neg = 1'b1;
                count_char();
                return;
            end
        end
        if (tok_phase == dntp_pkg::PH_INT) begin
            if (is_digit(c)) begin
                n = 64'(int_acc) * 64'd10 + 64'(c - dntp_pkg::CH_ZERO);
                if (!tok_mode)
                    n = n & 64'hFFFF_FFFF;
                else if (n > 64'(dntp_pkg::INT_MAX_MAG))
                    n = 64'(dntp_pkg::INT_MAX_MAG);
                int_acc   = n[32:0];
                got_digit = 1'b1;
                count_char();
                return;
            end
            if (tok_mode && c == dntp_pkg::CH_POINT) begin
                tok_phase = dntp_pkg::PH_FRAC;
                count_char();
                return;
            end
        end else if (is_digit(c)) begin
            got_digit = 1'b1;
            if (frac_cnt < dntp_pkg::FRAC_DIGITS) begin
                frac_acc = 17'(frac_acc * 10 + 32'(c - dntp_pkg::CH_ZERO));
                frac_cnt = frac_cnt + 3'd1;
            end
            count_char();
            return;
        end
        close_token(c, res);
        done = 1'b1;
    endtask

    always @(posedge aclk) begin : watch
        token_t got;
        token_t want;
        token_t nxt;
        bit     done;
        if (!aresetn) begin
            cfg_mode  = 1'b0;
            tok_mode  = 1'b0;
            tok_phase = dntp_pkg::PH_IDLE;
            clear_token();
            base_pos  = '0;
            token_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.value    = m_tdata[47:0];
                got.position = m_tdata[63:48];
                got.ok       = m_tuser[0];
                n_res++;
                if (got.ok)
                    n_ok++;
                if (token_q.size() == 0) begin
                    report_mismatch("result with no token pending", 64'(got), 64'd0);
                end else begin
                    want = token_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", 64'(got.value), 64'(want.value));
                    if (got.ok !== want.ok)
                        report_mismatch("ok", 64'(got.ok), 64'(want.ok));
                    if (got.position !== want.position)
                        report_mismatch("position", 64'(got.position),
                                        64'(want.position));
                end
            end
            if (cfg_we)
                cfg_mode = cfg_wdata[0];
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata[7:0], s_tuser[0], s_tdata[23:8], done, nxt);
                if (done)
                    token_q.push_back(nxt);
            end
        end
        err_count     <= n_err;
        pending_count <= token_q.size();
        result_count  <= n_res;
        ok_count      <= n_ok;
    end

endmodule

>>> tb/sv/tb_decimal_number_token_parser_top.sv
// ----------------------------------------------------------------------------
// Decimal token parser testbench
// Drives short directed tokens in both modes, then mostly well-formed random
// tokens with noise, random gaps on both sides and one long receiver stall.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_decimal_number_token_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_WORDS  = 125;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [0:0]  cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    int chk_errors;
    int chk_pending;
    int chk_results;
    int chk_ok;

    int cycle_count = 0;
    int n_words     = 0;
    int n_tokens    = 0;
    int n_settings  = 0;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;
    bit steady      = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    decimal_number_token_parser_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    dntp_token_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .err_count     (chk_errors),
        .pending_count (chk_pending),
        .result_count  (chk_results),
        .ok_count      (chk_ok)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, chk_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? dntp_pkg::CH_SPACE : dntp_pkg::CH_TAB + 8'(r);
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic start,
                             input logic [15:0] off);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {off, ch};
        s_tuser  <= start;
        @(posedge aclk iff s_tready);
        n_words++;
        if (start)
            n_tokens++;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string s, input logic [15:0] off);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == 0, (i == 0) ? off : 16'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (chk_pending != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_mode(input logic m);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    initial begin : sink
        int r;
        int span;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                    span = $urandom_range(1, 30);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    span = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    span = $urandom_range(10, 50);
                end
                repeat (span) @(posedge aclk);
            end
        end
    end

    initial begin : source
        logic [7:0]  tok_q[$];
        logic [15:0] off;
        logic        cur_mode;
        int          phase_start;
        int          r;
        int          cnt;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_mode(1'b0);
        send_word("x", 1'b0, 16'h0000);
        send_text("\t7,", 16'hFFFF);
        send_text("5", 16'd3);
        send_text("9", 16'd10);
        send_word(dntp_pkg::CH_NUL, 1'b0, 16'h0000);
        send_text("-3 ", 16'd0);

        set_mode(1'b1);
        send_text("-.5 ", 16'd1);
        send_text("5.x", 16'd2);
        send_text("- ", 16'd0);
        send_text(".99999,", 16'h8000);

        for (int ph = 0; ph < 4; ph++) begin
            cur_mode = (ph % 2 == 0);
            set_mode(cur_mode);
            if (ph == 1)
                hold_go = 1'b1;
            steady = (ph == 2);
            phase_start = n_words;
            while (n_words - phase_start < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              16'($urandom));
                end else begin
                    tok_q.delete();
                    r = $urandom_range(0, 3);
                    off = (r == 0) ? 16'h0000 :
                          (r == 1) ? 16'hFFFF - 16'($urandom_range(0, 8)) :
                                     16'($urandom);
                    cnt = $urandom_range(0, 5);
                    if (cnt > 3)
                        cnt = 0;
                    repeat (cnt) tok_q.push_back(pick_space());
                    if ($urandom_range(0, 3) == 0)
                        tok_q.push_back(dntp_pkg::CH_MINUS);
                    r = $urandom_range(0, 9);
                    cnt = (r < 8) ? $urandom_range(1, 5) :
                          (r == 8) ? 0 : $urandom_range(9, 12);
                    repeat (cnt) begin
                        if (cnt > 8 && $urandom_range(0, 1) == 0)
                            tok_q.push_back(dntp_pkg::CH_NINE);
                        else
                            tok_q.push_back(dntp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    if (cur_mode && $urandom_range(0, 2) == 0) begin
                        tok_q.push_back(dntp_pkg::CH_POINT);
                        repeat ($urandom_range(0, 8))
                            tok_q.push_back(dntp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        tok_q.push_back(pick_space());
                    else if (r < 6)
                        tok_q.push_back(dntp_pkg::CH_NUL);
                    else if (r < 8)
                        tok_q.push_back(dntp_pkg::CH_COMMA);
                    else if (r == 8)
                        tok_q.push_back(8'($urandom_range(0, 255)));
                    foreach (tok_q[i])
                        send_word(tok_q[i], i == 0, (i == 0) ? off : 16'($urandom));
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d words in %0d tokens over %0d mode settings.",
                 n_words, n_tokens, n_settings);
        $display("Checked %0d results, %0d of them ok, with %0d mismatches.",
                 chk_results, chk_ok, chk_errors);
        if (chk_errors == 0 && chk_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
